### rtl/acstep_pkg.sv
package acstep_pkg;

   // data memory geometry
   localparam int MEM_DEPTH = 128;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   // operand bits that form a memory address
   localparam logic [7:0] ADDR_MASK = 8'h7F;
   localparam logic [7:0] PC_STEP   = 8'd2;

   // mode codes
   localparam logic MODE_EXEC = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // opcodes
   localparam logic [7:0] OP_JZ  = 8'd0;
   localparam logic [7:0] OP_LDA = 8'd1;
   localparam logic [7:0] OP_STA = 8'd2;
   localparam logic [7:0] OP_ADD = 8'd3;
   localparam logic [7:0] OP_SUB = 8'd4;
   localparam logic [7:0] OP_JMP = 8'd5;
   localparam logic [7:0] OP_LDB = 8'd6;
   localparam logic [7:0] OP_HLT = 8'd7;

   typedef struct packed {
      logic [7:0] pc;
      logic [7:0] acc;
      logic [7:0] breg;
      logic       zero;
      logic       halted;
   } cpu_state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } mem_wr_type;

   // masked operand folded into the memory; at most seven folds for depth >= 16
   function automatic logic [ADDR_W-1:0] mem_addr(input logic [7:0] operand);
      logic [8:0] v;
      v = {1'b0, operand & ADDR_MASK};
      for (int i = 0; i < 8; i++) begin
         if (v >= 9'(MEM_DEPTH)) begin
            v = v - 9'(MEM_DEPTH);
         end
      end
      return v[ADDR_W-1:0];
   endfunction

endpackage

### rtl/acstep_ram.sv
module acstep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/acstep_exec.sv
module acstep_exec
   import acstep_pkg::*;
(
   input  cpu_state_type     cur,
   input  logic              mode,
   input  logic [7:0]        opcode,
   input  logic [7:0]        operand,
   input  logic [7:0]        load_value,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        mem_rd,
   output cpu_state_type     nxt,
   output logic              bad,
   output mem_wr_type        wr
);

   logic [7:0] pc_next;
   logic [7:0] sum;
   logic [7:0] diff;

   assign pc_next = cur.pc + PC_STEP;
   assign sum     = cur.acc + cur.breg;
   assign diff    = cur.acc - cur.breg;

   always_comb begin
      nxt     = cur;
      bad     = 1'b0;
      wr.en   = 1'b0;
      wr.addr = addr;
      wr.data = cur.acc;
      if (mode == MODE_LOAD) begin
         wr.en   = 1'b1;
         wr.data = load_value;
      end else if (!cur.halted) begin
         unique case (opcode)
            OP_JZ: begin
               nxt.pc = cur.zero ? operand : pc_next;
            end
            OP_LDA: begin
               nxt.acc  = mem_rd;
               nxt.zero = (mem_rd == 8'd0);
               nxt.pc   = pc_next;
            end
            OP_STA: begin
               wr.en  = 1'b1;
               nxt.pc = pc_next;
            end
            OP_ADD: begin
               nxt.acc  = sum;
               nxt.zero = (sum == 8'd0);
               nxt.pc   = pc_next;
            end
            OP_SUB: begin
               nxt.acc  = diff;
               nxt.zero = (diff == 8'd0);
               nxt.pc   = pc_next;
            end
            OP_JMP: begin
               nxt.pc = operand;
            end
            OP_LDB: begin
               nxt.breg = mem_rd;
               nxt.pc   = pc_next;
            end
            OP_HLT: begin
               nxt.halted = 1'b1;
            end
            default: begin
               nxt.halted = 1'b1;
               bad        = 1'b1;
            end
         endcase
      end
   end

endmodule

### rtl/accumulator_cpu_instruction_step_core.sv
// Channel   Dir  Handshake          Word
// req_      in   req_valid/stall    mode, opcode, operand, load_value
// rsp_      out  rsp_valid/stall    pc_out, acc_out, breg_out, zero_out,
//                                   halted_out, bad_opcode
//
// Accepted words pass the input stage, then the result register; one word per cycle while rsp_stall is low.
// Input stage: operand latched, data memory read issued (registered read port).
// Execute: instruction executes, machine state and memory commit, result
//          register loads. A write in the same edge as the next read is
//          forwarded into that read.
// Reset clears registers, flags and per-byte valid bits (unwritten bytes
// read as zero); no clearing pass. A stalled result holds the input stage,
// which, if empty, still takes one more word before req_stall rises.
module accumulator_cpu_instruction_step_core
   import acstep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_opcode,
   input  logic [7:0] req_operand,
   input  logic [7:0] req_load_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_pc_out,
   output logic [7:0] rsp_acc_out,
   output logic [7:0] rsp_breg_out,
   output logic       rsp_zero_out,
   output logic       rsp_halted_out,
   output logic       rsp_bad_opcode
);

   // handshake
   logic req_accept;
   logic s1_fire;

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_mode_ff;
   logic [7:0]        s1_opcode_ff;
   logic [7:0]        s1_operand_ff;
   logic [7:0]        s1_load_value_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [ADDR_W-1:0] req_addr;

   // memory and bypass
   logic [MEM_DEPTH-1:0] mem_valid_ff;
   logic                 fwd_hit_ff;
   logic [7:0]           fwd_data_ff;
   logic [7:0]           ram_q;
   logic [7:0]           mem_rd;

   // machine state
   cpu_state_type st_ff;
   cpu_state_type st_in;
   logic          bad;
   mem_wr_type    wr;
   logic          wr_commit;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   cpu_state_type rsp_st_ff;
   logic          rsp_bad_ff;

   // input stage moves on whenever the result register is free or draining
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_fire;
   assign req_accept = req_valid && !req_stall;
   assign req_addr   = mem_addr(req_operand);

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);
   assign wr_commit    = s1_fire && wr.en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mem_valid_ff <= '0;
         fwd_hit_ff   <= 1'b0;
         st_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_commit) begin
            mem_valid_ff[wr.addr] <= 1'b1;
         end
         if (req_accept) begin
            // same-edge write to the address being read: ram returns old byte
            fwd_hit_ff <= wr_commit && (wr.addr == req_addr);
         end
         if (s1_fire) begin
            st_ff <= st_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff       <= req_mode;
         s1_opcode_ff     <= req_opcode;
         s1_operand_ff    <= req_operand;
         s1_load_value_ff <= req_load_value;
         s1_addr_ff       <= req_addr;
         fwd_data_ff      <= wr.data;
      end
      if (s1_fire) begin
         rsp_st_ff  <= st_in;
         rsp_bad_ff <= bad;
      end
   end

   acstep_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_commit),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (ram_q)
   );

   // bypass first, then unwritten bytes read as zero
   always_comb begin
      if (fwd_hit_ff) begin
         mem_rd = fwd_data_ff;
      end else if (mem_valid_ff[s1_addr_ff]) begin
         mem_rd = ram_q;
      end else begin
         mem_rd = 8'd0;
      end
   end

   acstep_exec u_exec (
      .cur        (st_ff),
      .mode       (s1_mode_ff),
      .opcode     (s1_opcode_ff),
      .operand    (s1_operand_ff),
      .load_value (s1_load_value_ff),
      .addr       (s1_addr_ff),
      .mem_rd     (mem_rd),
      .nxt        (st_in),
      .bad        (bad),
      .wr         (wr)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pc_out     = rsp_st_ff.pc;
   assign rsp_acc_out    = rsp_st_ff.acc;
   assign rsp_breg_out   = rsp_st_ff.breg;
   assign rsp_zero_out   = rsp_st_ff.zero;
   assign rsp_halted_out = rsp_st_ff.halted;
   assign rsp_bad_opcode = rsp_bad_ff;

`ifndef NO_ASSERTIONS
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      st_ff.halted |=> st_ff.halted)
      else $error("halt flag cleared without reset");

   a_halt_frozen: assert property (@(posedge clock) disable iff (reset)
      st_ff.halted |=> $stable(st_ff.pc) && $stable(st_ff.acc)
                       && $stable(st_ff.breg) && $stable(st_ff.zero))
      else $error("machine state changed while halted");

   a_bad_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_opcode |-> rsp_halted_out)
      else $error("bad opcode reported without halt");

   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid)
      else $error("executed word produced no result");
`endif

endmodule

### tb/acstep_state_checker.sv
module acstep_state_checker
   import acstep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_opcode,
   input  logic [7:0] req_operand,
   input  logic [7:0] req_load_value,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_pc_out,
   input  logic [7:0] rsp_acc_out,
   input  logic [7:0] rsp_breg_out,
   input  logic       rsp_zero_out,
   input  logic       rsp_halted_out,
   input  logic       rsp_bad_opcode,
   output int         fail_count,
   output int         results_owed,
   output int         results_checked
);

   typedef struct packed {
      logic [7:0] pc;
      logic [7:0] acc;
      logic [7:0] breg;
      logic       zero;
      logic       halted;
      logic       bad;
   } machine_view_type;

   // shadow machine
   logic [7:0] m_acc, m_breg, m_pc;
   logic       m_zero, m_halted;
   logic [7:0] m_mem [MEM_DEPTH];

   machine_view_type expected_states [$];

   // one instruction or memory load; returns the machine state after it
   function automatic machine_view_type execute_word(input logic       mode,
                                                     input logic [7:0] opcode,
                                                     input logic [7:0] operand,
                                                     input logic [7:0] value);
      machine_view_type view;
      int               a;
      logic [7:0]       after_pc;
      logic             bad;
      a        = int'(operand & ADDR_MASK) % MEM_DEPTH;
      after_pc = m_pc + PC_STEP;
      bad      = 1'b0;
      if (mode == MODE_LOAD) begin
         m_mem[a] = value;
      end else if (!m_halted) begin
         case (opcode)
            OP_JZ: begin
               m_pc = m_zero ? operand : after_pc;
            end
            OP_LDA: begin
               m_acc  = m_mem[a];
               m_zero = (m_acc == 8'd0);
               m_pc   = after_pc;
            end
            OP_STA: begin
               m_mem[a] = m_acc;
               m_pc     = after_pc;
            end
            OP_ADD: begin
               m_acc  = m_acc + m_breg;
               m_zero = (m_acc == 8'd0);
               m_pc   = after_pc;
            end
            OP_SUB: begin
               m_acc  = m_acc - m_breg;
               m_zero = (m_acc == 8'd0);
               m_pc   = after_pc;
            end
            OP_JMP: begin
               m_pc = operand;
            end
            OP_LDB: begin
               m_breg = m_mem[a];
               m_pc   = after_pc;
            end
            OP_HLT: begin
               m_halted = 1'b1;
            end
            default: begin
               m_halted = 1'b1;
               bad      = 1'b1;
            end
         endcase
      end
      view.pc     = m_pc;
      view.acc    = m_acc;
      view.breg   = m_breg;
      view.zero   = m_zero;
      view.halted = m_halted;
      view.bad    = bad;
      return view;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      machine_view_type want;
      if (reset) begin
         m_acc    = 8'd0;
         m_breg   = 8'd0;
         m_pc     = 8'd0;
         m_zero   = 1'b0;
         m_halted = 1'b0;
         for (int i = 0; i < MEM_DEPTH; i++) m_mem[i] = 8'd0;
         expected_states.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_states.size() == 0) begin
               fail_count++;
               $display("%0t unexpected result: expected none actual pc %0h acc %0h",
                        $time, rsp_pc_out, rsp_acc_out);
            end else begin
               want = expected_states.pop_front();
               results_checked++;
               check_field("pc_out",     want.pc,            rsp_pc_out);
               check_field("acc_out",    want.acc,           rsp_acc_out);
               check_field("breg_out",   want.breg,          rsp_breg_out);
               check_field("zero_out",   {7'd0, want.zero},   {7'd0, rsp_zero_out});
               check_field("halted_out", {7'd0, want.halted}, {7'd0, rsp_halted_out});
               check_field("bad_opcode", {7'd0, want.bad},    {7'd0, rsp_bad_opcode});
            end
         end
         if (req_valid && !req_stall)
            expected_states.push_back(execute_word(req_mode, req_opcode, req_operand,
                                                   req_load_value));
      end
      results_owed = expected_states.size();
   end

endmodule

### tb/accumulator_cpu_instruction_step_core_tb.sv
module accumulator_cpu_instruction_step_core_tb
   import acstep_pkg::*;
();

   // idle cycles with no word moving on either channel before giving up;
   // the slowest legal stretch is a source gap plus a sink stall
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_WORDS   = 1100;
   localparam int CALM_WORDS     = 100;   // tail of the running part, no idling
   localparam int HALTED_WORDS   = 40;
   localparam int DRAIN_CYCLES   = 8;     // pipe drain margin

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic       req_mode       = 1'b0;
   logic [7:0] req_opcode     = 8'd0;
   logic [7:0] req_operand    = 8'd0;
   logic [7:0] req_load_value = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_pc_out;
   logic [7:0] rsp_acc_out;
   logic [7:0] rsp_breg_out;
   logic       rsp_zero_out;
   logic       rsp_halted_out;
   logic       rsp_bad_opcode;

   int fail_count;
   int results_owed;
   int results_checked;

   // calm = no source gaps and no sink stalls
   logic calm = 1'b0;
   int   loads_sent = 0;
   int   execs_sent = 0;
   int   stall_hold = 0;
   int   idle_cycles = 0;

   always #5 clock = ~clock;

   accumulator_cpu_instruction_step_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_opcode     (req_opcode),
      .req_operand    (req_operand),
      .req_load_value (req_load_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pc_out     (rsp_pc_out),
      .rsp_acc_out    (rsp_acc_out),
      .rsp_breg_out   (rsp_breg_out),
      .rsp_zero_out   (rsp_zero_out),
      .rsp_halted_out (rsp_halted_out),
      .rsp_bad_opcode (rsp_bad_opcode)
   );

   acstep_state_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_opcode      (req_opcode),
      .req_operand     (req_operand),
      .req_load_value  (req_load_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pc_out      (rsp_pc_out),
      .rsp_acc_out     (rsp_acc_out),
      .rsp_breg_out    (rsp_breg_out),
      .rsp_zero_out    (rsp_zero_out),
      .rsp_halted_out  (rsp_halted_out),
      .rsp_bad_opcode  (rsp_bad_opcode),
      .fail_count      (fail_count),
      .results_owed    (results_owed),
      .results_checked (results_checked)
   );

   // Sink side: random stall bursts separated by free runs.
   // Only one NBA to rsp_stall per edge.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold > 0) begin
         stall_hold--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_hold = $urandom_range(0, 20);
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_hold = $urandom_range(0, 9);
      end
   end

   // Watchdog: counts edges where no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no traffic for %0d cycles, %0d results owed",
                     $time, idle_cycles, results_owed);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Present one word and hold it until accepted. Called at a rising edge.
   // An optional idle gap goes in front of the word.
   task automatic issue_word(input logic mode, input logic [7:0] opcode,
                             input logic [7:0] operand, input logic [7:0] value);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_opcode     <= opcode;
      req_operand    <= operand;
      req_load_value <= value;
      do @(posedge clock); while (req_stall);
      if (mode == MODE_LOAD) loads_sent++;
      else execs_sent++;
   endtask

   // execute word; load_value is don't-care, so randomize it
   task automatic run_op(input logic [7:0] opcode, input logic [7:0] operand);
      issue_word(MODE_EXEC, opcode, operand, 8'($urandom));
   endtask

   // memory load word; opcode is ignored, so randomize it
   task automatic put_byte(input logic [7:0] operand, input logic [7:0] value);
      issue_word(MODE_LOAD, 8'($urandom), operand, value);
   endtask

   initial begin
      int         pick;
      logic [7:0] byte_val;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed: extremes, wraparound, every live opcode ----
      run_op(OP_LDA, 8'h05);        // unwritten byte reads zero, sets zero flag
      run_op(OP_JZ, 8'hFE);         // taken jump
      put_byte(8'hFF, 8'hFF);       // bit 7 masked: top byte of memory
      put_byte(8'h80, 8'h01);       // masked down to byte zero
      run_op(OP_LDA, 8'h7F);        // acc = FF, pc FE -> 00 wraps
      run_op(OP_LDB, 8'h80);        // breg = 01
      run_op(OP_ADD, 8'h00);        // FF + 1 wraps to zero
      run_op(OP_SUB, 8'h00);        // 0 - 1 wraps to FF
      run_op(OP_JZ, 8'h33);         // not taken
      run_op(OP_STA, 8'h10);
      run_op(OP_LDB, 8'h90);        // reads back the stored FF
      run_op(OP_SUB, 8'h00);        // FF - FF = 0
      run_op(OP_ADD, 8'h00);
      put_byte(8'hA0, 8'h00);
      run_op(OP_JMP, 8'hFF);
      run_op(OP_LDB, 8'h20);        // breg = 0, pc FF -> 01 wraps
      run_op(OP_JMP, 8'h00);
      put_byte(8'h55, 8'hAA);
      run_op(OP_LDA, 8'hD5);
      run_op(OP_STA, 8'h7F);
      run_op(OP_LDA, 8'hFF);

      // ---- random running program: live opcodes and loads, no halt yet ----
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
         pick = $urandom_range(0, 3);
         if (pick == 0) begin
            // bias toward zero bytes so the zero flag and taken JZ show up
            byte_val = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
            put_byte(8'($urandom), byte_val);
         end else begin
            run_op(8'($urandom_range(0, 6)), 8'($urandom));
         end
      end

      // ---- unknown opcode halts the machine, then it must stay frozen ----
      run_op(8'($urandom_range(8, 255)), 8'($urandom));
      run_op(OP_HLT, 8'($urandom));
      for (int n = 0; n < HALTED_WORDS; n++) begin
         if ($urandom_range(0, 2) == 0) put_byte(8'($urandom), 8'($urandom));
         else run_op(8'($urandom), 8'($urandom));
      end

      req_valid <= 1'b0;
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d execute and %0d load words, %0d results compared,",
               execs_sent, loads_sent, results_checked);
      $display("ending with an unknown-opcode halt and a frozen-machine tail");
      if (fail_count == 0 && results_owed == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
